@@ rtl/core/smq_pkg.sv @@
package smq_pkg;

    // Sizing of the text store and the digit row
    localparam int TEXT_DEPTH = 64;
    localparam int MAX_DIGITS = 8;
    localparam int TEXT_AW    = $clog2(TEXT_DEPTH + 1);
    localparam int MEM_AW     = (TEXT_DEPTH > 1) ? $clog2(TEXT_DEPTH) : 1;
    localparam int ADDR_W     = $clog2(TEXT_DEPTH + MAX_DIGITS + 2);
    localparam int IDX_W      = $clog2(MAX_DIGITS + 2);

    // Fixed field widths
    localparam int BYTE_W      = 8;
    localparam int DELAY_W     = 32;
    localparam int CNT_W       = 4;
    localparam int DIG_IDX_W   = 3;
    localparam int CFG_IDX_W   = 2;

    // Register reset values
    localparam logic [DELAY_W-1:0] CHAR_DELAY_RST  = DELAY_W'(250000);
    localparam logic [DELAY_W-1:0] END_DELAY_RST   = DELAY_W'(1000000);
    localparam logic [CNT_W-1:0]   DIGIT_COUNT_RST = CNT_W'(8);

    // Character codes
    localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0] CH_NL    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;

    // Input function and result kind codes
    localparam logic FUNC_TEXT  = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;
    localparam logic KIND_DIGIT = 1'b0;
    localparam logic KIND_SCHED = 1'b1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHAR_DELAY  = 2'd0,
        CFG_END_DELAY   = 2'd1,
        CFG_DIGIT_COUNT = 2'd2
    } t_cfg_reg;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NL_OUT,
        ST_FIRST,
        ST_SCAN,
        ST_DECIDE,
        ST_DIG,
        ST_SCHED
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic take_in;
        logic idx_clr;
        logic idx_inc;
        logic scan_base;
        logic cap_first;
        logic scan_chk;
        logic decide;
        logic emit_digit;
        logic emit_sched;
        logic commit;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic out_free;
        logic nl_start;
        logic tick_go;
        logic scan_go;
        logic scan_done;
        logic digits_zero;
        logic last_digit;
        logic stop;
    } t_stat;

endpackage

@@ rtl/core/smq_ctrl.sv @@
module smq_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  smq_pkg::t_stat i_stat,
    output smq_pkg::t_cmd  o_cmd
);

    smq_pkg::t_state r_state;
    smq_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= smq_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            smq_pkg::ST_IDLE: begin
                if (i_in_valid && i_stat.nl_start) begin
                    n_state = smq_pkg::ST_NL_OUT;
                end else if (i_in_valid && i_stat.tick_go) begin
                    n_state = smq_pkg::ST_FIRST;
                end
            end
            smq_pkg::ST_NL_OUT: begin
                if (i_stat.out_free) begin
                    n_state = smq_pkg::ST_IDLE;
                end
            end
            smq_pkg::ST_FIRST: begin
                n_state = i_stat.scan_go ? smq_pkg::ST_SCAN : smq_pkg::ST_DECIDE;
            end
            smq_pkg::ST_SCAN: begin
                if (i_stat.scan_done) begin
                    n_state = smq_pkg::ST_DECIDE;
                end
            end
            smq_pkg::ST_DECIDE: begin
                if (!i_stat.digits_zero) begin
                    n_state = smq_pkg::ST_DIG;
                end else begin
                    n_state = i_stat.stop ? smq_pkg::ST_IDLE : smq_pkg::ST_SCHED;
                end
            end
            smq_pkg::ST_DIG: begin
                if (i_stat.out_free && i_stat.last_digit) begin
                    n_state = i_stat.stop ? smq_pkg::ST_IDLE : smq_pkg::ST_SCHED;
                end
            end
            smq_pkg::ST_SCHED: begin
                if (i_stat.out_free) begin
                    n_state = smq_pkg::ST_IDLE;
                end
            end
            default: n_state = smq_pkg::ST_IDLE;
        endcase
    end

    // Command outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            smq_pkg::ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.idx_clr = 1'b1;
                o_cmd.take_in = i_in_valid;
            end
            smq_pkg::ST_NL_OUT: begin
                o_cmd.emit_sched = i_stat.out_free;
            end
            smq_pkg::ST_FIRST: begin
                o_cmd.cap_first = 1'b1;
                o_cmd.scan_base = 1'b1;
                o_cmd.idx_clr   = 1'b1;
            end
            smq_pkg::ST_SCAN: begin
                o_cmd.scan_chk  = 1'b1;
                o_cmd.scan_base = 1'b1;
                o_cmd.idx_inc   = 1'b1;
            end
            smq_pkg::ST_DECIDE: begin
                o_cmd.decide  = 1'b1;
                o_cmd.idx_clr = 1'b1;
                o_cmd.commit  = i_stat.digits_zero && i_stat.stop;
            end
            smq_pkg::ST_DIG: begin
                o_cmd.emit_digit = i_stat.out_free;
                o_cmd.idx_inc    = i_stat.out_free;
                o_cmd.commit     = i_stat.out_free && i_stat.last_digit && i_stat.stop;
            end
            smq_pkg::ST_SCHED: begin
                o_cmd.emit_sched = i_stat.out_free;
                o_cmd.commit     = i_stat.out_free;
            end
            default: o_cmd = '0;
        endcase
    end

    // Only one result word is loaded per cycle
    a_one_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.emit_digit && o_cmd.emit_sched))
        else $error("digit and schedule words loaded together");

    // Finishing a timer word always returns to idle
    a_commit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> (r_state == smq_pkg::ST_IDLE))
        else $error("commit did not end the update");

    // The digit phase is never entered with no digits to drive
    a_dig_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == smq_pkg::ST_DIG) |-> !i_stat.digits_zero)
        else $error("digit phase with zero digits");

endmodule

@@ rtl/core/smq_datapath.sv @@
module smq_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic [smq_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [smq_pkg::DELAY_W-1:0]         i_cfg_data,
    input  logic                                i_func,
    input  logic [smq_pkg::BYTE_W-1:0]          i_data_byte,
    input  logic                                i_out_ready,
    input  smq_pkg::t_cmd                       i_cmd,
    output smq_pkg::t_stat                      o_stat,
    output logic                                o_out_valid,
    output logic                                o_result_kind,
    output logic [smq_pkg::DIG_IDX_W-1:0]       o_digit_index,
    output logic [smq_pkg::BYTE_W-1:0]          o_digit_char,
    output logic [smq_pkg::DELAY_W-1:0]         o_next_delay,
    output logic                                o_last
);

    // Configuration registers
    logic [smq_pkg::DELAY_W-1:0] r_char_delay;
    logic [smq_pkg::DELAY_W-1:0] r_end_delay;
    logic [smq_pkg::CNT_W-1:0]   r_digit_count;

    // Text store: bytes in memory, terminator handled by per-entry valid bits
    logic [smq_pkg::BYTE_W-1:0]     r_mem [smq_pkg::TEXT_DEPTH];
    logic [smq_pkg::TEXT_DEPTH-1:0] r_valid;
    logic [smq_pkg::BYTE_W-1:0]     r_rd_mem;
    logic                           r_rd_ok;

    // Marquee state
    logic [smq_pkg::TEXT_AW-1:0] r_rp;
    logic [smq_pkg::TEXT_AW-1:0] r_wp;
    logic                        r_running;
    logic                        r_blink_phase;
    logic                        r_head_nz;

    // Per-update working registers
    logic [smq_pkg::IDX_W-1:0]   r_idx;
    logic [smq_pkg::IDX_W-1:0]   n_idx;
    logic                        r_blink;
    logic                        r_stopped;
    logic [smq_pkg::BYTE_W-1:0]  r_first;
    logic [smq_pkg::DELAY_W-1:0] r_delay;

    // Output register
    logic                          r_out_valid;
    logic                          r_out_kind;
    logic [smq_pkg::DIG_IDX_W-1:0] r_out_idx;
    logic [smq_pkg::BYTE_W-1:0]    r_out_char;
    logic [smq_pkg::DELAY_W-1:0]   r_out_delay;
    logic                          r_out_last;

    logic [smq_pkg::IDX_W-1:0]   digits;
    logic [smq_pkg::TEXT_AW-1:0] base;
    logic [smq_pkg::ADDR_W-1:0]  addr;
    logic [smq_pkg::MEM_AW-1:0]  addr_m;
    logic [smq_pkg::BYTE_W-1:0]  rdata;
    logic [smq_pkg::BYTE_W-1:0]  dig_ch;
    logic [smq_pkg::TEXT_AW-1:0] wp1;
    logic [smq_pkg::MEM_AW-1:0]  wp_m;
    logic [smq_pkg::MEM_AW-1:0]  wp1_m;
    logic [smq_pkg::DELAY_W-1:0] quarter;
    logic                        is_text;
    logic                        is_nl;
    logic                        wr_en;
    logic                        nl_wr;
    logic                        scan_ok;
    logic                        first_zero;
    logic                        stop;
    logic                        last_digit;
    logic                        out_free;
    logic                        emit;

    // Clamp driven digit count
    assign digits = (int'(r_digit_count) > smq_pkg::MAX_DIGITS)
                  ? smq_pkg::IDX_W'(smq_pkg::MAX_DIGITS)
                  : smq_pkg::IDX_W'(r_digit_count);

    // Walk index and read address
    always_comb begin
        if (i_cmd.idx_clr) begin
            n_idx = '0;
        end else if (i_cmd.idx_inc) begin
            n_idx = r_idx + smq_pkg::IDX_W'(1);
        end else begin
            n_idx = r_idx;
        end
    end

    assign base   = i_cmd.scan_base ? (r_rp - smq_pkg::TEXT_AW'(1)) : r_rp;
    assign addr   = smq_pkg::ADDR_W'(base) + smq_pkg::ADDR_W'(n_idx);
    assign addr_m = addr[smq_pkg::MEM_AW-1:0];
    assign rdata  = r_rd_ok ? r_rd_mem : smq_pkg::CH_NUL;

    // Text write decode
    assign is_text = i_cmd.take_in && (i_func == smq_pkg::FUNC_TEXT);
    assign is_nl   = is_text && (i_data_byte == smq_pkg::CH_NL);
    assign wr_en   = is_text && (i_data_byte != smq_pkg::CH_NL)
                  && (i_data_byte != smq_pkg::CH_CR)
                  && (r_wp < smq_pkg::TEXT_AW'(smq_pkg::TEXT_DEPTH));
    assign nl_wr   = is_nl && (r_wp < smq_pkg::TEXT_AW'(smq_pkg::TEXT_DEPTH));
    assign wp1     = r_wp + smq_pkg::TEXT_AW'(1);
    assign wp_m    = r_wp[smq_pkg::MEM_AW-1:0];
    assign wp1_m   = wp1[smq_pkg::MEM_AW-1:0];

    // Update decisions
    assign scan_ok    = !r_blink_phase && (rdata != smq_pkg::CH_NUL) && (r_rp != '0);
    assign first_zero = (r_first == smq_pkg::CH_NUL);
    assign stop       = first_zero && ((r_end_delay == '0) || !r_head_nz);
    assign last_digit = (r_idx == (digits - smq_pkg::IDX_W'(1)));
    assign quarter    = r_delay >> 2;
    assign dig_ch     = (r_blink || r_stopped || (rdata == smq_pkg::CH_NUL))
                      ? smq_pkg::CH_SPACE : rdata;
    assign out_free   = !r_out_valid || i_out_ready;
    assign emit       = i_cmd.emit_digit || i_cmd.emit_sched;

    // Status to controller
    always_comb begin
        o_stat             = '0;
        o_stat.out_free    = out_free;
        o_stat.nl_start    = (i_func == smq_pkg::FUNC_TEXT)
                          && (i_data_byte == smq_pkg::CH_NL) && !r_running;
        o_stat.tick_go     = (i_func == smq_pkg::FUNC_TICK) && r_running;
        o_stat.scan_go     = scan_ok && (digits != '0);
        o_stat.scan_done   = (rdata != r_first) || (r_idx == digits);
        o_stat.digits_zero = (digits == '0);
        o_stat.last_digit  = last_digit;
        o_stat.stop        = stop;
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_char_delay  <= smq_pkg::CHAR_DELAY_RST;
            r_end_delay   <= smq_pkg::END_DELAY_RST;
            r_digit_count <= smq_pkg::DIGIT_COUNT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                smq_pkg::CFG_CHAR_DELAY:  r_char_delay  <= i_cfg_data;
                smq_pkg::CFG_END_DELAY:   r_end_delay   <= i_cfg_data;
                smq_pkg::CFG_DIGIT_COUNT: r_digit_count <= i_cfg_data[smq_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Text memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wp_m] <= i_data_byte;
        end
        r_rd_mem <= r_mem[addr_m];
    end

    // Entry valid bits; an invalid entry reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            r_rd_ok <= (addr < smq_pkg::ADDR_W'(smq_pkg::TEXT_DEPTH)) && r_valid[addr_m];
            if (wr_en) begin
                r_valid[wp_m] <= 1'b1;
                if (wp1 < smq_pkg::TEXT_AW'(smq_pkg::TEXT_DEPTH)) begin
                    r_valid[wp1_m] <= 1'b0;
                end
            end
            if (nl_wr) begin
                r_valid[wp_m] <= 1'b0;
            end
        end
    end

    // Marquee control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rp          <= '0;
            r_wp          <= '0;
            r_running     <= 1'b0;
            r_blink_phase <= 1'b0;
            r_head_nz     <= 1'b0;
            r_idx         <= '0;
            r_blink       <= 1'b0;
            r_stopped     <= 1'b0;
        end else begin
            r_idx <= n_idx;
            if (is_nl) begin
                r_wp <= '0;
                if (r_wp == '0) begin
                    r_head_nz <= 1'b0;
                end
                if (!r_running) begin
                    r_running     <= 1'b1;
                    r_blink_phase <= 1'b0;
                    r_rp          <= '0;
                end
            end
            if (wr_en) begin
                r_wp <= wp1;
                r_rp <= '0;
                if (r_wp == '0) begin
                    r_head_nz <= (i_data_byte != smq_pkg::CH_NUL);
                end
            end
            if (i_cmd.cap_first) begin
                r_blink <= scan_ok;
            end
            if (i_cmd.scan_chk && (rdata != r_first)) begin
                r_blink <= 1'b0;
            end
            if (i_cmd.decide) begin
                r_blink_phase <= r_blink;
                r_stopped     <= 1'b0;
            end
            if (i_cmd.emit_digit && (rdata == smq_pkg::CH_NUL)) begin
                r_stopped <= 1'b1;
            end
            if (i_cmd.commit) begin
                if (first_zero) begin
                    r_rp <= '0;
                end else if (!r_blink) begin
                    r_rp <= r_rp + smq_pkg::TEXT_AW'(1);
                end
                if (stop) begin
                    r_running <= 1'b0;
                end
            end
        end
    end

    // First character and delay of the update
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_first) begin
            r_first <= rdata;
        end
        if (is_nl && !r_running) begin
            r_delay <= r_char_delay;
        end else if (i_cmd.cap_first) begin
            r_delay <= (rdata == smq_pkg::CH_NUL) ? r_end_delay : r_char_delay;
        end else if (i_cmd.decide && (r_blink != r_blink_phase)) begin
            r_delay <= r_blink ? quarter : (r_delay - quarter);
        end
    end

    // Output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_digit) begin
            r_out_kind  <= smq_pkg::KIND_DIGIT;
            r_out_idx   <= smq_pkg::DIG_IDX_W'(r_idx);
            r_out_char  <= dig_ch;
            r_out_delay <= '0;
            r_out_last  <= last_digit && stop;
        end else if (i_cmd.emit_sched) begin
            r_out_kind  <= smq_pkg::KIND_SCHED;
            r_out_idx   <= '0;
            r_out_char  <= smq_pkg::CH_NUL;
            r_out_delay <= r_delay;
            r_out_last  <= 1'b1;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_result_kind = r_out_kind;
    assign o_digit_index = r_out_idx;
    assign o_digit_char  = r_out_char;
    assign o_next_delay  = r_out_delay;
    assign o_last        = r_out_last;

    // A word is only loaded when the output slot can take it
    a_emit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> (!r_out_valid || i_out_ready))
        else $error("output word overwritten");

    // Blink phase only exists while the marquee runs
    a_blink_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_blink_phase |-> r_running)
        else $error("blink phase while stopped");

    // Walk index stays within one scan of the digit window
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_idx) <= smq_pkg::MAX_DIGITS + 1)
        else $error("walk index out of range");

endmodule

@@ rtl/core/segment_marquee_scroller.sv @@
// Marquee scroller for a row of up to eight character digits. Text words
// (func 0) append to a 64-byte store; a newline ends the line and,
// when the marquee is stopped, returns one schedule word with char_delay.
// A timer word (func 1) while running returns digit_count (at most eight) digit
// words and, unless the line stops, one schedule word; last marks the final one.
// A timer word walks the single read port of the text store, one entry per
// cycle, once for the blink check when it runs and once for the digit walk,
// which holds while the output is stalled. Configuration is always ready and
// is to be written only while the block is idle.
module segment_marquee_scroller (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [smq_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [smq_pkg::DELAY_W-1:0]     i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_func,
    input  logic [smq_pkg::BYTE_W-1:0]      i_data_byte,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_result_kind,
    output logic [smq_pkg::DIG_IDX_W-1:0]   o_digit_index,
    output logic [smq_pkg::BYTE_W-1:0]      o_digit_char,
    output logic [smq_pkg::DELAY_W-1:0]     o_next_delay,
    output logic                            o_last
);

    smq_pkg::t_cmd  cmd;
    smq_pkg::t_stat stat;

    // Registers take a write every cycle
    assign o_cfg_ready = 1'b1;

    smq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    smq_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_func        (i_func),
        .i_data_byte   (i_data_byte),
        .i_out_ready   (i_out_ready),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_out_valid   (o_out_valid),
        .o_result_kind (o_result_kind),
        .o_digit_index (o_digit_index),
        .o_digit_char  (o_digit_char),
        .o_next_delay  (o_next_delay),
        .o_last        (o_last)
    );

endmodule

@@ verif/tb_top.sv @@
module tb_top;
    import smq_pkg::*;

    // One result word as the scroller returns it
    typedef struct packed {
        logic                 kind;
        logic [DIG_IDX_W-1:0] idx;
        logic [BYTE_W-1:0]    chr;
        logic [DELAY_W-1:0]   delay;
        logic                 last;
    } disp_word_t;

    // Directed stimulus row; fixed_n < 0 means the predictor supplies the words
    typedef struct {
        logic               func;
        logic [BYTE_W-1:0]  data;
        int                 fixed_n;
        logic [DELAY_W-1:0] fixed_delay;
    } stim_row_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    t_cfg_reg              i_cfg_index = CFG_CHAR_DELAY;
    logic [DELAY_W-1:0]    i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic                  i_func = FUNC_TEXT;
    logic [BYTE_W-1:0]     i_data_byte = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic                  o_result_kind;
    logic [DIG_IDX_W-1:0]  o_digit_index;
    logic [BYTE_W-1:0]     o_digit_char;
    logic [DELAY_W-1:0]    o_next_delay;
    logic                  o_last;

    // Shadow copy of the scroller state and registers
    logic [BYTE_W-1:0]  txt [0:TEXT_DEPTH] = '{default: 8'h00};
    int unsigned        rd_pos = 0;
    int unsigned        wr_pos = 0;
    bit                 blink_on = 1'b0;
    bit                 scrolling = 1'b0;
    logic [DELAY_W-1:0] cfg_char_delay = CHAR_DELAY_RST;
    logic [DELAY_W-1:0] cfg_end_delay = END_DELAY_RST;
    logic [CNT_W-1:0]   cfg_digits = DIGIT_COUNT_RST;

    disp_word_t step_words[$];
    disp_word_t pending_words[$];

    int  fail_count = 0;
    int  items_done = 0;
    int  ticks_done = 0;
    int  blink_steps = 0;
    int  words_seen = 0;
    int  settings_done = 0;
    bit  src_quiet = 1'b0;
    bit  snk_quiet = 1'b0;

    // Directed part: idle timer, empty line, a run of repeats that blinks,
    // bytes and newlines while scrolling, extreme and zero bytes
    stim_row_t dir_rows [24] = '{
        '{FUNC_TICK, 8'hFF,    0, '0},              // timer while stopped: dropped
        '{FUNC_TEXT, CH_CR,    0, '0},              // carriage return: dropped
        '{FUNC_TEXT, CH_NL,    1, CHAR_DELAY_RST},  // empty line still starts
        '{FUNC_TICK, 8'h00,   -1, '0},              // all spaces, then stops
        '{FUNC_TEXT, 8'h41,   -1, '0},
        '{FUNC_TEXT, 8'h41,   -1, '0},
        '{FUNC_TEXT, 8'h41,   -1, '0},
        '{FUNC_TEXT, 8'h41,   -1, '0},
        '{FUNC_TEXT, 8'h41,   -1, '0},
        '{FUNC_TEXT, 8'h41,   -1, '0},
        '{FUNC_TEXT, 8'h41,   -1, '0},
        '{FUNC_TEXT, 8'h41,   -1, '0},
        '{FUNC_TEXT, 8'h41,   -1, '0},
        '{FUNC_TEXT, CH_NL,    1, CHAR_DELAY_RST},
        '{FUNC_TICK, 8'h00,   -1, '0},              // position zero: no blink
        '{FUNC_TICK, 8'h55,   -1, '0},              // same window: blink
        '{FUNC_TICK, 8'hAA,   -1, '0},              // leave blink
        '{FUNC_TICK, 8'hFF,   -1, '0},
        '{FUNC_TEXT, CH_CR,    0, '0},
        '{FUNC_TEXT, 8'hFF,   -1, '0},
        '{FUNC_TEXT, CH_NL,    0, '0},              // already running: no word
        '{FUNC_TICK, 8'h00,   -1, '0},
        '{FUNC_TEXT, 8'h00,   -1, '0},              // zero byte is stored
        '{FUNC_TICK, 8'h00,   -1, '0}
    };

    segment_marquee_scroller u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_func        (i_func),
        .i_data_byte   (i_data_byte),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_result_kind (o_result_kind),
        .o_digit_index (o_digit_index),
        .o_digit_char  (o_digit_char),
        .o_next_delay  (o_next_delay),
        .o_last        (o_last)
    );

    always #1 i_clk = ~i_clk;

    function automatic logic [BYTE_W-1:0] text_at(input int unsigned i);
        return (i <= TEXT_DEPTH) ? txt[i] : CH_NUL;
    endfunction

    function automatic void add_word(input logic kind, input logic [DIG_IDX_W-1:0] idx,
                                     input logic [BYTE_W-1:0] chr,
                                     input logic [DELAY_W-1:0] delay);
        disp_word_t w;
        w = '{kind: kind, idx: idx, chr: chr, delay: delay, last: 1'b0};
        step_words.push_back(w);
    endfunction

    // Words caused by one input word; updates the shadow state
    function automatic void marquee_step(input logic func, input logic [BYTE_W-1:0] b);
        int unsigned        digits, pos, l;
        logic [BYTE_W-1:0]  first, prev, ch;
        bit                 blink;
        logic [DELAY_W-1:0] delay;
        step_words.delete();
        if (func == FUNC_TEXT) begin
            if (b == CH_NL) begin
                txt[wr_pos] = CH_NUL;
                wr_pos = 0;
                if (!scrolling) begin
                    scrolling = 1'b1;
                    blink_on = 1'b0;
                    rd_pos = 0;
                    add_word(KIND_SCHED, '0, CH_NUL, cfg_char_delay);
                end
            end else if (b != CH_CR && wr_pos < TEXT_DEPTH) begin
                txt[wr_pos] = b;
                txt[wr_pos + 1] = CH_NUL;
                wr_pos++;
                rd_pos = 0;
            end
        end else if (scrolling) begin
            digits = (cfg_digits > MAX_DIGITS) ? MAX_DIGITS : cfg_digits;
            first = text_at(rd_pos);
            delay = (first == CH_NUL) ? cfg_end_delay : cfg_char_delay;
            blink = 1'b0;
            // blink when the next window repeats the previous character
            if (!blink_on && first != CH_NUL && rd_pos > 0) begin
                prev = text_at(rd_pos - 1);
                blink = 1'b1;
                for (l = 0; l < digits; l++) begin
                    ch = text_at(rd_pos + l);
                    if (ch == CH_NUL || ch != prev) begin
                        blink = 1'b0;
                        break;
                    end
                    prev = ch;
                end
            end
            if (blink != blink_on) begin
                blink_on = blink;
                delay = blink ? (delay >> 2) : delay - (delay >> 2);
                if (blink) blink_steps++;
            end
            pos = rd_pos;
            for (l = 0; l < digits; l++) begin
                ch = blink ? CH_NUL : text_at(pos);
                if (ch != CH_NUL) pos++;
                else ch = CH_SPACE;
                add_word(KIND_DIGIT, l[DIG_IDX_W-1:0], ch, '0);
            end
            // end of line: wrap, and stop on a single pass or empty text
            if (first == CH_NUL) begin
                rd_pos = 0;
                if (cfg_end_delay == 0 || txt[0] == CH_NUL) scrolling = 1'b0;
                else blink_on = 1'b0;
            end else if (!blink) begin
                rd_pos++;
            end
            if (scrolling) add_word(KIND_SCHED, '0, CH_NUL, delay);
        end
        if (step_words.size() > 0) step_words[$].last = 1'b1;
    endfunction

    // Random idle length: mostly none, some short, a few long
    function automatic int idle_len(input bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Send one input word, then queue what it should return
    task automatic send_word(input logic func, input logic [BYTE_W-1:0] b,
                             input int fixed_n, input logic [DELAY_W-1:0] fixed_delay);
        int gap;
        bit counted;
        gap = idle_len(src_quiet);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_func      <= func;
        i_data_byte <= b;
        do @(posedge i_clk); while (!o_in_ready);
        counted = (func == FUNC_TEXT) ? (b != CH_CR) : scrolling;
        if (counted) items_done++;
        if (func == FUNC_TICK && scrolling) ticks_done++;
        marquee_step(func, b);
        if (fixed_n < 0) begin
            foreach (step_words[i]) pending_words.push_back(step_words[i]);
        end else if (fixed_n == 1) begin
            pending_words.push_back('{kind: KIND_SCHED, idx: '0, chr: CH_NUL,
                                      delay: fixed_delay, last: 1'b1});
        end
    endtask

    // A line of text, its newline and a run of timer words; lines of up to twelve bytes get more timer words than bytes
    task automatic send_line();
        int len, n_ticks, k;
        bit runs;
        logic [BYTE_W-1:0] c;
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 12);
        runs = $urandom_range(0, 1);
        c = 8'h78;
        for (k = 0; k < len; k++) begin
            if (!runs) c = $urandom_range(0, 255);
            else if ($urandom_range(0, 3) == 0) c = $urandom_range(0, 1) ? 8'h78 : 8'h79;
            send_word(FUNC_TEXT, c, -1, '0);
        end
        send_word(FUNC_TEXT, CH_NL, -1, '0);
        n_ticks = (len > 12) ? $urandom_range(2, 10) : len + $urandom_range(1, 8);
        repeat (n_ticks) send_word(FUNC_TICK, $urandom_range(0, 255), -1, '0);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [DELAY_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_CHAR_DELAY: cfg_char_delay = val;
            CFG_END_DELAY:  cfg_end_delay = val;
            default:        cfg_digits = val[CNT_W-1:0];
        endcase
    endtask

    function automatic void check_field(input string name, input logic [DELAY_W-1:0] exp_val,
                                        input logic [DELAY_W-1:0] act_val);
        if (exp_val !== act_val) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_val, act_val);
            fail_count++;
        end
    endfunction

    // Output stalls: runs of ready broken by random gaps
    initial begin : sink_stall
        int gap;
        forever begin
            i_out_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            gap = idle_len(snk_quiet);
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    // Compare each returned word with the oldest expectation
    always @(posedge i_clk) begin : result_check
        disp_word_t w;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_words.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual kind %0d idx %0d char %h delay %h last %0d",
                         $time, o_result_kind, o_digit_index, o_digit_char, o_next_delay, o_last);
                fail_count++;
            end else begin
                w = pending_words.pop_front();
                check_field("result_kind", w.kind, o_result_kind);
                check_field("digit_index", w.idx, o_digit_index);
                check_field("digit_char", w.chr, o_digit_char);
                check_field("next_delay", w.delay, o_next_delay);
                check_field("last", w.last, o_last);
                words_seen++;
            end
        end
    end

    initial begin : stimulus
        logic [DELAY_W-1:0] chr_d, end_d;
        logic [CNT_W-1:0]   dig;
        int r, phase_start;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (dir_rows[i])
            send_word(dir_rows[i].func, dir_rows[i].data, dir_rows[i].fixed_n,
                      dir_rows[i].fixed_delay);

        for (int p = 0; p < 7; p++) begin
            // let the block go idle before touching the registers
            i_in_valid <= 1'b0;
            while (pending_words.size() != 0) @(posedge i_clk);
            repeat (40) @(posedge i_clk);
            case (p)
                0: begin chr_d = '0;         end_d = '0;         dig = 4'd1;  end
                1: begin chr_d = '1;         end_d = '1;         dig = 4'd8;  end
                2: begin chr_d = $urandom(); end_d = '0;         dig = 4'd15; end
                3: begin chr_d = $urandom(); end_d = $urandom(); dig = 4'd0;  end
                4: begin chr_d = $urandom(); end_d = $urandom(); dig = $urandom_range(2, 4); end
                5: begin chr_d = $urandom(); end_d = '0;         dig = $urandom_range(1, 8); end
                default: begin
                    chr_d = $urandom(); end_d = $urandom(); dig = $urandom_range(0, 15);
                end
            endcase
            write_reg(CFG_CHAR_DELAY, chr_d);
            write_reg(CFG_END_DELAY, end_d);
            write_reg(CFG_DIGIT_COUNT, DELAY_W'(dig));
            i_cfg_valid <= 1'b0;
            settings_done++;
            src_quiet = ($urandom_range(0, 3) == 0);
            snk_quiet = ($urandom_range(0, 3) == 0);
            phase_start = items_done;
            while (items_done - phase_start < 37) begin
                r = $urandom_range(0, 99);
                if (r < 70)
                    send_line();
                else if (r < 85)
                    repeat ($urandom_range(1, 4))
                        send_word($urandom_range(0, 1), $urandom_range(0, 255), -1, '0);
                else if (r < 93)
                    repeat ($urandom_range(1, 5))
                        send_word(FUNC_TEXT, $urandom_range(32, 126), -1, '0);
                else
                    repeat ($urandom_range(1, 5))
                        send_word(FUNC_TICK, $urandom_range(0, 255), -1, '0);
            end
        end

        i_in_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        $display("Covered %0d input words (%0d timer updates, %0d blink steps) under %0d register settings,",
                 items_done, ticks_done, blink_steps, settings_done + 1);
        $display("and checked %0d result words field by field.", words_seen);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Backstop against a hung handshake
    initial begin : watchdog
        #1200000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
